// ----- hdl/hfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_pkg
// shared constants and types of the hole fit allocator: table geometry,
// operation and status codes, and the job record passed front to back
// ----------------------------------------------------------------------------
package hfa_pkg;

	localparam int MAX_HOLES = 16;
	localparam int SIZE_BITS = 16;

	localparam int IDX_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int CNT_BITS = $clog2(MAX_HOLES + 1);

	localparam int FUNC_BITS   = 1;
	localparam int REQ_BITS    = 16;
	localparam int STATUS_BITS = 2;
	localparam int OUT_IDX     = 4;
	localparam int OUT_SIZE    = 16;

	localparam logic [FUNC_BITS-1:0] FUNC_LOAD = 1'b0;
	localparam logic                 MODE_FIRST = 1'b0;

	typedef enum logic {
		OP_LOAD,
		OP_FIT
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_FITTED,
		ST_NOFIT,
		ST_LOADED,
		ST_FULL
	} status_t;

	typedef struct packed {
		op_t                  op;
		logic [SIZE_BITS-1:0] size;
	} job_t;

endpackage
`default_nettype wire

// ----- hdl/hfa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
module hfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hfa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_front
// accepts input transfers, classifies them as load or fit jobs and queues
// them in a two entry fifo towards the back end
// ----------------------------------------------------------------------------
module hfa_front import hfa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [FUNC_BITS-1:0] func,
	input  wire logic [REQ_BITS-1:0] request_size,
	output logic                     job_valid,
	input  wire logic                job_ready,
	output job_t                     job
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	job_t       in_job;
	logic       push;
	logic       pop;

	always_comb begin
		in_job.op   = (func == FUNC_LOAD) ? OP_LOAD : OP_FIT;
		in_job.size = SIZE_BITS'(request_size);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hfa_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hfa_back
// executes queued jobs: appends holes, scans the hole table one entry a
// cycle for a first or best fit, updates the chosen hole and holds the
// result in an output register
// ----------------------------------------------------------------------------
module hfa_back import hfa_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fit_mode,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire job_t                   job,
	output logic                        mem_wr_en,
	output logic [IDX_BITS-1:0]         mem_wr_addr,
	output logic [SIZE_BITS-1:0]        mem_wr_data,
	output logic                        mem_rd_en,
	output logic [IDX_BITS-1:0]         mem_rd_addr,
	input  wire logic [SIZE_BITS-1:0]   mem_rd_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [STATUS_BITS-1:0]      status,
	output logic [OUT_IDX-1:0]          hole_index,
	output logic [OUT_SIZE-1:0]         size_before,
	output logic [OUT_SIZE-1:0]         size_after
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [SIZE_BITS-1:0]  size_q;
	logic [CNT_BITS-1:0]   iss_q;
	logic                  dv_q;
	logic [IDX_BITS-1:0]   didx_q;
	logic                  found_q;
	logic [IDX_BITS-1:0]   pick_q;
	logic [SIZE_BITS-1:0]  best_q;
	logic                  res_valid_q;
	status_t               res_status_q;
	logic [OUT_IDX-1:0]    res_idx_q;
	logic [OUT_SIZE-1:0]   res_before_q;
	logic [OUT_SIZE-1:0]   res_after_q;

	logic                  start;
	logic                  full;
	logic                  hit;
	logic                  take;
	logic                  last;
	logic                  stop;
	logic [SIZE_BITS-1:0]  remain;

	assign job_ready = (state_q == S_IDLE) && !res_valid_q;
	assign start     = job_valid && job_ready;
	assign full      = (count_q == CNT_BITS'(MAX_HOLES));
	assign hit       = dv_q && (size_q <= mem_rd_data);
	assign take      = hit && ((fit_mode == MODE_FIRST) || !found_q || (mem_rd_data <= best_q));
	assign last      = dv_q && ((CNT_BITS'(didx_q) + CNT_BITS'(1)) == count_q);
	assign stop      = (hit && (fit_mode == MODE_FIRST)) || last;
	assign remain    = best_q - size_q;

	// one write port shared by hole loading and the fit update
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[IDX_BITS-1:0];
		mem_wr_data = job.size;
		if (state_q == S_DONE) begin
			mem_wr_en   = found_q;
			mem_wr_addr = pick_q;
			mem_wr_data = remain;
		end else if (start && (job.op == OP_LOAD) && !full) begin
			mem_wr_en = 1'b1;
		end
	end

	assign mem_rd_en   = (state_q == S_SCAN) && (iss_q < count_q);
	assign mem_rd_addr = iss_q[IDX_BITS-1:0];

	assign out_valid   = res_valid_q;
	assign status      = res_status_q;
	assign hole_index  = res_idx_q;
	assign size_before = res_before_q;
	assign size_after  = res_after_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			size_q       <= '0;
			iss_q        <= '0;
			dv_q         <= 1'b0;
			didx_q       <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			best_q       <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= ST_FITTED;
			res_idx_q    <= '0;
			res_before_q <= '0;
			res_after_q  <= '0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (job.op == OP_LOAD) begin
							res_valid_q  <= 1'b1;
							res_before_q <= '0;
							res_after_q  <= '0;
							if (full) begin
								res_status_q <= ST_FULL;
								res_idx_q    <= '0;
							end else begin
								res_status_q <= ST_LOADED;
								res_idx_q    <= OUT_IDX'(count_q);
								count_q      <= count_q + CNT_BITS'(1);
							end
						end else begin
							size_q  <= job.size;
							iss_q   <= '0;
							dv_q    <= 1'b0;
							found_q <= 1'b0;
							if (count_q == '0) begin
								res_valid_q  <= 1'b1;
								res_status_q <= ST_NOFIT;
								res_idx_q    <= '0;
								res_before_q <= '0;
								res_after_q  <= '0;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					dv_q   <= mem_rd_en && !stop;
					didx_q <= iss_q[IDX_BITS-1:0];
					if (mem_rd_en) begin
						iss_q <= iss_q + CNT_BITS'(1);
					end
					if (take) begin
						found_q <= 1'b1;
						pick_q  <= didx_q;
						best_q  <= mem_rd_data;
					end
					if (stop) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					res_valid_q <= 1'b1;
					if (found_q) begin
						res_status_q <= ST_FITTED;
						res_idx_q    <= OUT_IDX'(pick_q);
						res_before_q <= OUT_SIZE'(best_q);
						res_after_q  <= OUT_SIZE'(remain);
					end else begin
						res_status_q <= ST_NOFIT;
						res_idx_q    <= '0;
						res_before_q <= '0;
						res_after_q  <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hole_fit_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hole_fit_allocator
// first fit / best fit hole allocator over a table of free hole sizes
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   func, request_size
//   out      output     out_valid / out_ready status, hole_index, size_before,
//                                             size_after
//   cfg      input      cfg_valid / cfg_ready cfg_data (fit mode)
//
// with an empty queue a load result passes the job queue and then the result
// register after its input transfer; a fit result also waits for the scan of
// the hole ram, one entry a cycle, which is skipped on an empty table
// reset empties the hole table and selects first fit; no clearing pass
// a two entry job queue keeps accepting transfers while the back end works
// or its result waits; the back end starts a job once the result is taken
// ----------------------------------------------------------------------------
module hole_fit_allocator import hfa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [FUNC_BITS-1:0]  func,
	input  wire logic [REQ_BITS-1:0]   request_size,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [STATUS_BITS-1:0]     status,
	output logic [OUT_IDX-1:0]         hole_index,
	output logic [OUT_SIZE-1:0]        size_before,
	output logic [OUT_SIZE-1:0]        size_after
);

	logic                  fit_mode_q;
	logic                  job_valid;
	logic                  job_ready;
	job_t                  job;
	logic                  mem_wr_en;
	logic [IDX_BITS-1:0]   mem_wr_addr;
	logic [SIZE_BITS-1:0]  mem_wr_data;
	logic                  mem_rd_en;
	logic [IDX_BITS-1:0]   mem_rd_addr;
	logic [SIZE_BITS-1:0]  mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
		end else if (cfg_valid && cfg_ready) begin
			fit_mode_q <= cfg_data;
		end
	end

	hfa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.request_size (request_size),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job)
	);

	hfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_HOLES)
	) u_holes (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	hfa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fit_mode    (fit_mode_q),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.hole_index  (hole_index),
		.size_before (size_before),
		.size_after  (size_after)
	);

endmodule
`default_nettype wire
